>>> rtl/core/ppfm_pkg.sv
// Shared constants, codes and types for the peak-period frequency meter.
`default_nettype none

package ppfm_pkg;

	// Field and state widths
	localparam int TIME_BITS       = 48;
	localparam int VOLT_BITS       = 16;
	localparam int PEAK_COUNT_BITS = 16;
	localparam int TOTAL_BITS      = 64;
	localparam int FREQ_BITS       = 50;
	localparam int HYST_BITS       = VOLT_BITS - 1;
	localparam int FRAME_BITS      = 40;
	localparam int CFG_DATA_BITS   = FRAME_BITS;
	localparam int CFG_IDX_BITS    = 1;

	// Wave-lost timeout compare width: max of 2*period and 2*frame
	localparam int LOST_BITS = (TIME_BITS > FRAME_BITS) ? TIME_BITS + 1 : FRAME_BITS + 1;

	// Divider dividend: (peaks - 1) * 1e15
	localparam int DVD_BITS = PEAK_COUNT_BITS + FREQ_BITS;

	// Divider step counter width
	localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

	localparam logic [FREQ_BITS-1:0]  FREQ_MAX_MHZ = FREQ_BITS'(64'd1000000000000000);
	localparam logic [HYST_BITS-1:0]  HYST_RESET   = HYST_BITS'(100);
	localparam logic [FRAME_BITS-1:0] FRAME_RESET  = FRAME_BITS'(64'd50000000000);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_HYSTERESIS = 1'b0,
		CFG_FRAME      = 1'b1
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} ppfm_state_t;

	// Commands from the sequencer to the peak tracker
	typedef struct packed {
		logic lose;     // wave lost: clear period, total and count
		logic restart;  // averaging restart: clear total and count
	} trk_cmd_t;

	// Peak tracker state seen by the sequencer
	typedef struct packed {
		logic [PEAK_COUNT_BITS-1:0] peak_count;
		logic [TIME_BITS-1:0]       last_peak_time;
		logic [TIME_BITS-1:0]       last_period;
		logic [TOTAL_BITS-1:0]      period_total;
	} trk_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ppfm_div.sv
// Restoring divider, one quotient bit per cycle, used by the update ticks that recompute the average.
`default_nettype none

module ppfm_div
	import ppfm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DVD_BITS-1:0]   dividend,
	input  wire logic [TOTAL_BITS-1:0] divisor,
	output logic                       done,
	output logic [FREQ_BITS-1:0]       quotient
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [TOTAL_BITS-1:0]   rem_q;
	logic [TOTAL_BITS-1:0]   dsr_q;
	logic [DVD_BITS-1:0]     dvd_q;

	logic [TOTAL_BITS:0]   rem_sh;
	logic                  ge;
	logic [TOTAL_BITS:0]   rem_nx;

	// One shift-compare-subtract step
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_BITS-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_BITS'(DVD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: remainder, divisor, dividend shifting into quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx[TOTAL_BITS-1:0];
			dvd_q <= {dvd_q[DVD_BITS-2:0], ge};
		end
	end

	// Quotient is below 1e15 since dividend / divisor < 1e15
	assign done     = done_q;
	assign quotient = dvd_q[FREQ_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/core/ppfm_trk.sv
// Peak tracker: hysteresis level follower, peak detection and period accumulation.
`default_nettype none

module ppfm_trk
	import ppfm_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        sample_en,
	input  wire logic [TIME_BITS-1:0]        now,
	input  wire logic signed [VOLT_BITS-1:0] volt,
	input  wire logic [HYST_BITS-1:0]        hyst,
	input  wire trk_cmd_t                    cmd,
	output trk_stat_t                        stat
);

	logic signed [VOLT_BITS-1:0]  level_q;
	logic                         rising_q;
	logic                         falling_q;
	logic [PEAK_COUNT_BITS-1:0]   count_q;
	logic [TIME_BITS-1:0]         peak_time_q;
	logic [TIME_BITS-1:0]         period_q;
	logic [TOTAL_BITS-1:0]        total_q;

	logic signed [VOLT_BITS:0]    delta;
	logic signed [VOLT_BITS:0]    h_s;
	logic                         rise;
	logic                         fall;
	logic                         peak;
	logic [TIME_BITS-1:0]         since;
	logic [TOTAL_BITS:0]          sum;
	logic [TOTAL_BITS-1:0]        total_nx;

	// Level move against hysteresis, and the new period on a peak
	always_comb begin
		delta    = {volt[VOLT_BITS-1], volt} - {level_q[VOLT_BITS-1], level_q};
		h_s      = signed'({(VOLT_BITS + 1 - HYST_BITS)'(0), hyst});
		rise     = delta > h_s;
		fall     = !rise && (delta < -h_s);
		peak     = fall && rising_q && !falling_q;
		since    = now - peak_time_q;
		sum      = {1'b0, total_q} + (TOTAL_BITS + 1)'(since);
		total_nx = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			rising_q    <= 1'b0;
			falling_q   <= 1'b0;
			count_q     <= '0;
			peak_time_q <= '0;
			period_q    <= '0;
			total_q     <= '0;
		end else if (cmd.lose) begin
			period_q <= '0;
			total_q  <= '0;
			count_q  <= '0;
		end else if (cmd.restart) begin
			total_q <= '0;
			count_q <= '0;
		end else if (sample_en) begin
			if (rise) begin
				if (falling_q && !rising_q)
					falling_q <= 1'b0;
				rising_q <= 1'b1;
				level_q  <= volt;
			end else if (fall) begin
				if (peak) begin
					if (count_q != '0) begin
						period_q <= since;
						total_q  <= total_nx;
					end
					peak_time_q <= now;
					if (count_q != '1)
						count_q <= count_q + 1'b1;
					rising_q <= 1'b0;
				end
				falling_q <= 1'b1;
				level_q   <= volt;
			end
		end
	end

	assign stat.peak_count     = count_q;
	assign stat.last_peak_time = peak_time_q;
	assign stat.last_period    = period_q;
	assign stat.period_total   = total_q;

endmodule

`default_nettype wire

>>> rtl/core/peak_period_frequency_meter.sv
// Top level: config registers, tick sequencer, output register.
// Voltage samples: accepted every cycle while idle, produce no result.
// Update tick: result loaded in ST_DONE, reached from ST_EVAL (no division) or
// via ST_MUL and ST_DIV when the average is recomputed by the 66-step restoring divider.
// req_stall stays high from a tick's accept until its result is loaded.
// arst_n clears all state; hysteresis resets to 100 mV, frame to 50e9 ps.
`default_nettype none

module peak_period_frequency_meter
	import ppfm_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// item input
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic                        mode,
	input  wire logic [TIME_BITS-1:0]        time_ps,
	input  wire logic signed [VOLT_BITS-1:0] voltage_mv,
	// result output
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic [FREQ_BITS-1:0]             frequency_mhz,
	output logic                             changed,
	output logic                             wave_present,
	// configuration writes
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]    cfg_data
);

	ppfm_state_t state_q, state_nx;

	logic [HYST_BITS-1:0]       hyst_q;
	logic [FRAME_BITS-1:0]      frame_q;
	logic [TIME_BITS-1:0]       tick_time_q;
	logic [PEAK_COUNT_BITS-1:0] n_q;
	logic [TOTAL_BITS-1:0]      div_total_q;
	logic [FREQ_BITS-1:0]       f_q;
	logic [FREQ_BITS-1:0]       freq_q;
	logic                       rsp_valid_q;
	logic                       changed_q;
	logic                       wave_q;

	logic                       req_acc;
	logic                       sample_en;
	trk_cmd_t                   cmd;
	trk_stat_t                  stat;
	logic                       div_start;
	logic                       div_done;
	logic [FREQ_BITS-1:0]       div_quot;
	logic [DVD_BITS-1:0]        dividend;

	logic [TIME_BITS-1:0]       elapsed;
	logic [LOST_BITS-1:0]       lost_per;
	logic [LOST_BITS-1:0]       lost_frm;
	logic [LOST_BITS-1:0]       lost_lim;
	logic                       is_lost;
	logic [PEAK_COUNT_BITS-1:0] n_calc;
	logic                       clamp;
	logic                       out_free;

	assign req_acc   = req_valid && !req_stall;
	assign sample_en = req_acc && !mode;
	assign cfg_ready = 1'b1;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q  <= HYST_RESET;
			frame_q <= FRAME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HYSTERESIS: hyst_q  <= cfg_data[HYST_BITS-1:0];
				CFG_FRAME:      frame_q <= cfg_data[FRAME_BITS-1:0];
			endcase
		end
	end

	ppfm_trk u_trk (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_en (sample_en),
		.now       (time_ps),
		.volt      (voltage_mv),
		.hyst      (hyst_q),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Wave-lost test and average decision
	always_comb begin
		elapsed  = tick_time_q - stat.last_peak_time;
		lost_per = LOST_BITS'({stat.last_period, 1'b0});
		lost_frm = LOST_BITS'({frame_q, 1'b0});
		lost_lim = (lost_per < lost_frm) ? lost_frm : lost_per;
		is_lost  = LOST_BITS'(elapsed) > lost_lim;
		n_calc   = stat.peak_count - 1'b1;
		clamp    = (stat.period_total == '0) ||
			(TOTAL_BITS'(n_calc) >= stat.period_total);
	end

	// (peaks - 1) * 1e15, registered inside the divider
	assign dividend = DVD_BITS'(n_q) * DVD_BITS'(FREQ_MAX_MHZ);

	ppfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (div_total_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// Sequencer next state and strobes
	always_comb begin
		state_nx    = state_q;
		req_stall   = 1'b1;
		cmd.lose    = 1'b0;
		cmd.restart = 1'b0;
		div_start   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && mode)
					state_nx = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.last_period != '0) begin
					if (is_lost) begin
						cmd.lose = 1'b1;
						state_nx = ST_DONE;
					end else if (stat.peak_count > PEAK_COUNT_BITS'(1)) begin
						cmd.restart = 1'b1;
						state_nx    = clamp ? ST_DONE : ST_MUL;
					end else begin
						state_nx = ST_DONE;
					end
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_MUL: begin
				div_start = 1'b1;
				state_nx  = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Tick operands and candidate frequency
	always_ff @(posedge clk) begin
		if (req_acc && mode)
			tick_time_q <= time_ps;
		if (state_q == ST_EVAL) begin
			n_q         <= n_calc;
			div_total_q <= stat.period_total;
			if (stat.last_period == '0)
				f_q <= freq_q;
			else if (is_lost)
				f_q <= '0;
			else if (stat.peak_count > PEAK_COUNT_BITS'(1) && clamp)
				f_q <= FREQ_MAX_MHZ;
			else
				f_q <= freq_q;
		end else if (state_q == ST_DIV && div_done) begin
			f_q <= div_quot;
		end
	end

	// Frequency state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= '0;
			rsp_valid_q <= 1'b0;
			changed_q   <= 1'b0;
			wave_q      <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			freq_q      <= f_q;
			changed_q   <= f_q != freq_q;
			wave_q      <= stat.last_period != '0;
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign frequency_mhz = freq_q;
	assign changed       = changed_q;
	assign wave_present  = wave_q;

endmodule

`default_nettype wire

>>> rtl/core/ppfm_chk.sv
// Port-level checker for the frequency meter, bound to the top level.
`default_nettype none

module ppfm_chk
	import ppfm_pkg::*;
(
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_stall,
	input wire logic                        mode,
	input wire logic [TIME_BITS-1:0]        time_ps,
	input wire logic signed [VOLT_BITS-1:0] voltage_mv,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_stall,
	input wire logic [FREQ_BITS-1:0]        frequency_mhz,
	input wire logic                        changed,
	input wire logic                        wave_present,
	input wire logic                        cfg_valid,
	input wire logic                        cfg_ready,
	input wire logic [CFG_IDX_BITS-1:0]     cfg_index,
	input wire logic [CFG_DATA_BITS-1:0]    cfg_data
);

	// A stalled result is held
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(frequency_mhz))
		else $error("result dropped or changed while stalled");

	// Frequency never exceeds the clamp value
	a_freq_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> frequency_mhz <= FREQ_MAX_MHZ)
		else $error("frequency above limit");

	// No wave means zero frequency
	a_no_wave: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !wave_present |-> frequency_mhz == '0)
		else $error("nonzero frequency without a wave");

	// A tick holds off the next item while it is worked on
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && mode |=> req_stall)
		else $error("input taken during tick processing");

endmodule

bind peak_period_frequency_meter ppfm_chk u_ppfm_chk (.*);

`default_nettype wire

>>> tb/tb_peak_period_frequency_meter.sv
// Self-checking testbench for the peak-period frequency meter.

module tb_peak_period_frequency_meter;
	import ppfm_pkg::*;

	localparam bit MODE_SAMPLE = 1'b0;
	localparam bit MODE_TICK   = 1'b1;
	localparam int RING        = 256;   // readings in flight, far more than ever due
	localparam int CFG_SETTLE  = 80;    // longest tick latency plus margin
	localparam int LONG_HOLD   = 400;
	localparam int IDLE_LIMIT  = 3000;
	localparam int DIR_ROWS    = 22;

	typedef struct {
		logic [FREQ_BITS-1:0] freq;
		logic                 chg;
		logic                 wave;
	} meter_result_t;

	typedef struct {
		bit                   md;
		logic [TIME_BITS-1:0] t;
		int                   v;
		bit                   typed;
		logic [FREQ_BITS-1:0] f;
		bit                   c;
		bit                   w;
	} dir_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_stall;
	logic                        mode;
	logic [TIME_BITS-1:0]        time_ps;
	logic signed [VOLT_BITS-1:0] voltage_mv;
	logic                        rsp_valid;
	logic                        rsp_stall;
	logic [FREQ_BITS-1:0]        frequency_mhz;
	logic                        changed;
	logic                        wave_present;
	logic                        cfg_valid;
	logic                        cfg_ready;
	cfg_idx_t                    cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_data;

	peak_period_frequency_meter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.mode         (mode),
		.time_ps      (time_ps),
		.voltage_mv   (voltage_mv),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.frequency_mhz(frequency_mhz),
		.changed      (changed),
		.wave_present (wave_present),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Meter state as predicted from the accepted items
	logic [HYST_BITS-1:0]       m_hyst;
	logic [FRAME_BITS-1:0]      m_frame;
	int                         m_level;
	bit                         m_rise;
	bit                         m_fall;
	logic [PEAK_COUNT_BITS-1:0] m_peaks;
	logic [TIME_BITS-1:0]       m_peak_time;
	logic [TIME_BITS-1:0]       m_last_per;
	logic [TOTAL_BITS-1:0]      m_total;
	logic [FREQ_BITS-1:0]       m_freq;

	// Readings due: written by the stimulus side, read by the checker
	meter_result_t due_readings [RING];
	int unsigned   exp_wr;
	int unsigned   exp_rd;

	int                   mismatches;
	int                   burst_left;
	int                   hold_requests;
	int                   holds_served;
	logic [TIME_BITS-1:0] cur_time;
	dir_row_t             directed_rows [DIR_ROWS];

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predict the effect of one accepted item; a tick queues one reading
	function automatic void update_meter(bit md, logic [TIME_BITS-1:0] t,
			logic signed [VOLT_BITS-1:0] v);
		int                    delta;
		int                    h;
		logic [TOTAL_BITS-1:0] lost;
		logic [TOTAL_BITS-1:0] floor2;
		logic [TOTAL_BITS-1:0] n64;
		logic [TIME_BITS-1:0]  elapsed;
		logic [FREQ_BITS-1:0]  f;
		logic [127:0]          prod;
		meter_result_t         r;
		if (md == MODE_SAMPLE) begin
			delta = int'(v) - m_level;
			h = int'(m_hyst);
			if (delta > h) begin
				if (m_fall && !m_rise)
					m_fall = 1'b0;
				m_rise = 1'b1;
				m_level = int'(v);
			end else if (delta < -h) begin
				// a fall right after a rise is a peak
				if (m_rise && !m_fall) begin
					if (m_peaks != 0) begin
						m_last_per = t - m_peak_time;
						if (TOTAL_BITS'(m_last_per) > ~m_total)
							m_total = '1;
						else
							m_total = m_total + TOTAL_BITS'(m_last_per);
					end
					m_peak_time = t;
					if (m_peaks != '1)
						m_peaks = m_peaks + 1'b1;
					m_rise = 1'b0;
				end
				m_fall = 1'b1;
				m_level = int'(v);
			end
		end else begin
			f = m_freq;
			if (m_last_per != 0) begin
				lost = TOTAL_BITS'(m_last_per) << 1;
				floor2 = TOTAL_BITS'(m_frame) << 1;
				elapsed = t - m_peak_time;
				if (lost < floor2)
					lost = floor2;
				if (TOTAL_BITS'(elapsed) > lost) begin
					// wave lost
					f = '0;
					m_last_per = '0;
					m_total = '0;
					m_peaks = '0;
				end else if (m_peaks > 1) begin
					n64 = TOTAL_BITS'(m_peaks) - 1;
					if (m_total == 0 || n64 >= m_total) begin
						f = FREQ_MAX_MHZ;
					end else begin
						prod = 128'(n64) * 128'(FREQ_MAX_MHZ);
						f = FREQ_BITS'(prod / 128'(m_total));
					end
					m_total = '0;
					m_peaks = '0;
				end
			end
			r.chg = (f != m_freq);
			m_freq = f;
			r.freq = f;
			r.wave = (m_last_per != 0);
			due_readings[exp_wr % RING] = r;
			exp_wr++;
		end
	endfunction

	// Offer one item in bursts with random gaps; predict on accept
	task automatic offer(bit md, logic [TIME_BITS-1:0] t, logic signed [VOLT_BITS-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		mode <= md;
		time_ps <= t;
		voltage_mv <= v;
		do @(posedge clk); while (req_stall);
		update_meter(md, t, v);
	endtask

	// Write both registers once the meter is idle
	task automatic set_config(logic [HYST_BITS-1:0] hyst, logic [FRAME_BITS-1:0] frame);
		req_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HYSTERESIS;
		cfg_data <= CFG_DATA_BITS'(hyst);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_FRAME;
		cfg_data <= CFG_DATA_BITS'(frame);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_hyst = hyst;
		m_frame = frame;
	endtask

	// Triangle waves of random span, pace and noise, mixed with ticks and junk items
	task automatic run_wave_phase(int count, int tick_pct);
		int                   lo;
		int                   hi;
		int                   span;
		int                   half;
		int                   pos;
		int                   v;
		int                   r;
		int                   hmin;
		logic [TIME_BITS-1:0] dt;
		half = 1;
		pos = 0;
		lo = -100;
		hi = 100;
		dt = 1000;
		hmin = int'(m_hyst) + 1;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				offer(bit'($urandom_range(0, 1)), TIME_BITS'({$urandom, $urandom}),
					VOLT_BITS'($urandom));
			end else if (r < 8 + tick_pct) begin
				// now and then a long silence, so the wave gets lost
				if ($urandom_range(0, 5) == 0)
					cur_time += TIME_BITS'({$urandom, $urandom}) >> $urandom_range(0, 20);
				else
					cur_time += TIME_BITS'($urandom_range(0, 5000));
				offer(MODE_TICK, cur_time, VOLT_BITS'($urandom));
			end else begin
				if (pos == 0) begin
					half = $urandom_range(1, 6);
					if ($urandom_range(0, 3) != 0)
						span = $urandom_range(hmin, 65535);
					else
						span = $urandom_range(0, 65535);
					lo = -32768 + int'($urandom_range(0, 65535 - span));
					hi = lo + span;
					case ($urandom_range(0, 3))
						0: dt = TIME_BITS'($urandom_range(1, 100));
						1: dt = TIME_BITS'($urandom_range(1, 1 << 20));
						2: dt = TIME_BITS'($urandom_range(1, 1 << 30));
						default: dt = TIME_BITS'({$urandom, $urandom}) >> $urandom_range(8, 16);
					endcase
				end
				if (pos < half)
					v = lo + (hi - lo) * pos / half;
				else
					v = hi - (hi - lo) * (pos - half) / half;
				v = v + int'($urandom_range(0, 8)) - 4;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				cur_time += dt;
				offer(MODE_SAMPLE, cur_time, VOLT_BITS'(v));
				pos = (pos + 1) % (2 * half);
			end
		end
	endtask

	// Peaks almost one full time wrap apart: periods at the top of the time range
	task automatic run_peak_flood(int peaks);
		logic [TIME_BITS-1:0] t;
		t = cur_time;
		for (int k = 0; k < peaks; k++) begin
			offer(MODE_SAMPLE, t, VOLT_BITS'(1000));
			offer(MODE_SAMPLE, t, VOLT_BITS'(-1000));
			t = t - 1'b1;
		end
		offer(MODE_TICK, t + 1'b1, '0);
		cur_time = t + 1'b1;
	endtask

	// Reading checker and receiver stall pattern
	int stall_pct;
	int pat_left;
	int hold_left;
	meter_result_t got_exp;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (exp_wr == exp_rd) begin
					if (mismatches < 10)
						$display("unexpected reading: freq %0d changed %0b wave %0b",
							frequency_mhz, changed, wave_present);
					mismatches++;
				end else begin
					got_exp = due_readings[exp_rd % RING];
					exp_rd++;
					if (frequency_mhz !== got_exp.freq || changed !== got_exp.chg ||
							wave_present !== got_exp.wave) begin
						if (mismatches < 10)
							$display("mismatch: freq exp %0d got %0d, chg %0b/%0b, wave %0b/%0b",
								got_exp.freq, frequency_mhz, got_exp.chg, changed,
								got_exp.wave, wave_present);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= (hold_left != 0);
			end else if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = LONG_HOLD;
				rsp_stall <= 1'b1;
			end else begin
				if (pat_left == 0) begin
					pat_left = $urandom_range(16, 96);
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 30;
						3: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				pat_left--;
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Watchdog: cycles with no handshake on any channel
	int idle_cycles;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Main sequence
	initial begin
		logic [HYST_BITS-1:0]  h;
		logic [FRAME_BITS-1:0] f;
		arst_n = 1'b0;
		req_valid = 1'b0;
		mode = MODE_SAMPLE;
		time_ps = '0;
		voltage_mv = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HYSTERESIS;
		cfg_data = '0;
		exp_wr = 0;
		exp_rd = 0;
		mismatches = 0;
		burst_left = 0;
		hold_requests = 0;
		holds_served = 0;
		stall_pct = 0;
		pat_left = 0;
		hold_left = 0;
		idle_cycles = 0;
		cur_time = '0;
		m_hyst = HYST_RESET;
		m_frame = FRAME_RESET;
		m_level = 0;
		m_rise = 1'b0;
		m_fall = 1'b0;
		m_peaks = '0;
		m_peak_time = '0;
		m_last_per = '0;
		m_total = '0;
		m_freq = '0;

		// Reset values, full swings, time wrap, hysteresis edge, clamp to maximum
		directed_rows = '{
			'{MODE_TICK,   48'd0,               0,      1'b1, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd1000,            32767,  1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd2000,            -32768, 1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd3000,            32767,  1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd1002000,         -32768, 1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_TICK,   48'd1002010,         0,      1'b1, 50'd1000000000,       1'b1, 1'b1},
			'{MODE_TICK,   48'd1002020,         0,      1'b1, 50'd1000000000,       1'b0, 1'b1},
			'{MODE_TICK,   48'd200001002000,    0,      1'b1, 50'd0,                1'b1, 1'b0},
			'{MODE_TICK,   48'd200001003000,    0,      1'b1, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'hFFFF_FFFF_FE0C,  32767,  1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'hFFFF_FFFF_FE0C,  -32768, 1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'hFFFF_FFFF_FE70,  32767,  1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd500,             -32768, 1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd600,             -32668, 1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd700,             -32667, 1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd1500,            -32768, 1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_TICK,   48'd1600,            0,      1'b1, 50'd1000000000000,    1'b1, 1'b1},
			'{MODE_SAMPLE, 48'd2000,            0,      1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd2000,            -200,   1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd2001,            0,      1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_SAMPLE, 48'd2001,            -200,   1'b0, 50'd0,                1'b0, 1'b0},
			'{MODE_TICK,   48'd2002,            0,      1'b1, 50'd1000000000000000, 1'b1, 1'b1}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			offer(directed_rows[i].md, directed_rows[i].t, VOLT_BITS'(directed_rows[i].v));
			if (directed_rows[i].typed)
				due_readings[(exp_wr - 1) % RING] =
					'{directed_rows[i].f, directed_rows[i].c, directed_rows[i].w};
		end
		cur_time = 48'd10000;

		// Random phases over several register settings, extremes first
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					h = '0;
					f = FRAME_BITS'(1);
				end
				1: begin
					h = '1;
					f = '1;
				end
				2: begin
					h = HYST_RESET;
					f = FRAME_RESET;
				end
				default: begin
					h = HYST_BITS'($urandom_range(0, 32767));
					f = FRAME_BITS'({$urandom, $urandom}) >> $urandom_range(0, 39);
					if (f == 0)
						f = FRAME_BITS'(1);
				end
			endcase
			set_config(h, f);
			run_wave_phase(180, 12);
			if (p == 2) begin
				// receiver holds off while ticks keep coming, then drain
				hold_requests++;
				run_wave_phase(60, 45);
				req_valid <= 1'b0;
				while (exp_wr != exp_rd) @(posedge clk);
			end
		end

		set_config(HYST_RESET, '1);
		run_peak_flood(40);

		req_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
